// ===== src/egcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_pkg: shared types for the extended gcd block
// Controller states and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package egcd_pkg;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_COMMIT,
		ST_DONE
	} egcd_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture operands, seed coefficients
		logic div_init;  // clear remainder and accumulators, copy dividend
		logic div_step;  // one restoring division bit
		logic commit;    // rotate remainder and coefficient pairs
		logic publish;   // copy result into output register
	} egcd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic den_zero;  // current divisor is zero: loop ends
	} egcd_status_t;

endpackage
`default_nettype wire

// ===== src/egcd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_datapath: operand, remainder and coefficient registers
// Bit-serial restoring divider that builds q*x and q*y by Horner
// accumulation as quotient bits appear, so no multiplier is needed.
// Coefficients wrap modulo 2^(W+1).
// ----------------------------------------------------------------------------
module egcd_datapath
	import egcd_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire                            clk,
	input  wire egcd_cmd_t                 cmd,
	output egcd_status_t                   status,
	input  wire [OPERAND_WIDTH-1:0]        operand_a,
	input  wire [OPERAND_WIDTH-1:0]        operand_b,
	output logic [OPERAND_WIDTH-1:0]       gcd_value,
	output logic signed [OPERAND_WIDTH:0]  coeff_a,
	output logic signed [OPERAND_WIDTH:0]  coeff_b
);

	localparam int W = OPERAND_WIDTH;

	logic [W-1:0] num_q, den_q, dvd_q, rem_q;
	logic [W:0]   xp_q, xc_q, yp_q, yc_q, accx_q, accy_q;
	logic [W-1:0] gcd_q;
	logic [W:0]   ca_q, cb_q;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         ge;
	logic [W-1:0] rem_d;

	// trial subtract of one quotient bit
	always_comb begin
		trial = {rem_q, dvd_q[W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
		rem_d = ge ? diff[W-1:0] : trial[W-1:0];
	end

	// advance the operand and coefficient registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= operand_a;
			den_q <= operand_b;
			xp_q  <= (W+1)'(1);
			xc_q  <= '0;
			yp_q  <= '0;
			yc_q  <= (W+1)'(1);
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			dvd_q  <= num_q;
			accx_q <= '0;
			accy_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_d;
			dvd_q  <= {dvd_q[W-2:0], 1'b0};
			accx_q <= {accx_q[W-1:0], 1'b0} + (ge ? xc_q : '0);
			accy_q <= {accy_q[W-1:0], 1'b0} + (ge ? yc_q : '0);
		end
		if (cmd.commit) begin
			num_q <= den_q;
			den_q <= rem_q;
			xp_q  <= xc_q;
			xc_q  <= xp_q - accx_q;
			yp_q  <= yc_q;
			yc_q  <= yp_q - accy_q;
		end
		if (cmd.publish) begin
			gcd_q <= num_q;
			ca_q  <= xp_q;
			cb_q  <= yp_q;
		end
	end

	assign status.den_zero = (den_q == '0);
	assign gcd_value       = gcd_q;
	assign coeff_a         = $signed(ca_q);
	assign coeff_b         = $signed(cb_q);

endmodule
`default_nettype wire

// ===== src/egcd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_ctrl: sequencer for the extended gcd loop
// Walks load, divisor check, W division bits and commit per Euclid step,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module egcd_ctrl
	import egcd_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire          out_stall,
	output egcd_cmd_t    cmd,
	input  wire egcd_status_t status
);

	localparam int CNT_W = $clog2(OPERAND_WIDTH);

	egcd_state_t  state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic         out_valid_q;
	logic         last_bit;

	assign last_bit = (cnt_q == CNT_W'(OPERAND_WIDTH - 1));

	// hold state, bit counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.den_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (last_bit) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== src/extended_gcd_bezout_top.sv =====
`default_nettype none
// One transaction at a time; the next input is taken once the previous
// result sits in the output register. Each Euclid step runs the
// one-bit-per-cycle restoring divider. Asynchronous active-low reset clears
// the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// extended_gcd_bezout_top: gcd with Bezout coefficients
// Iterative extended Euclid: controller plus bit-serial datapath.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_top
	import egcd_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire [OPERAND_WIDTH-1:0]        operand_a,
	input  wire [OPERAND_WIDTH-1:0]        operand_b,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [OPERAND_WIDTH-1:0]       gcd_value,
	output logic signed [OPERAND_WIDTH:0]  coeff_a,
	output logic signed [OPERAND_WIDTH:0]  coeff_b
);

	egcd_cmd_t    cmd;
	egcd_status_t status;

	// sequencer
	egcd_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// arithmetic
	egcd_datapath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.status   (status),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.gcd_value(gcd_value),
		.coeff_a  (coeff_a),
		.coeff_b  (coeff_b)
	);

	// one transaction in flight: an accepted input stalls the next cycle
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is in flight");

	// a result is published only once the divisor reached zero
	a_publish_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> status.den_zero)
		else $error("result published before the loop ended");

	// a commit always follows the last division bit
	a_commit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(cmd.div_step))
		else $error("commit without a preceding division step");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.publish)
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire
